// File: design/chv_pkg.sv
// Shared types and constants for the container header validator.
// Holds the header layout, error codes and the record passed from front to back.
// No dependencies.
package chv_pkg;

   localparam int unsigned HDR_BYTES = 56;
   localparam int unsigned HDR_BITS  = HDR_BYTES * 8;
   localparam int unsigned CNT_W     = 6;

   localparam logic [31:0] MAGIC_PLAIN = 32'h0043_5458;
   localparam logic [31:0] MAGIC_HQ    = 32'h4843_5458;
   localparam logic [15:0] VER_NEW     = 16'd1;
   localparam logic [15:0] VER_OLD     = 16'd256;
   localparam logic [63:0] HDR_LEN_NEW = 64'd56;
   localparam logic [63:0] HDR_LEN_OLD = 64'd48;
   localparam logic [64:0] META_LEN    = 65'd256;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SHORT    = 3'd1,
      ERR_MAGIC    = 3'd2,
      ERR_VERSION  = 3'd3,
      ERR_PAGES    = 3'd4,
      ERR_INDEX    = 3'd5,
      ERR_META     = 3'd6,
      ERR_CHAPTERS = 3'd7
   } err_type;

   // One captured header, as handed from the byte collector to the checker.
   typedef struct packed {
      logic                short_hdr;
      logic [HDR_BITS-1:0] hdr;
   } entry_type;

   // Decoded fields of one verdict.
   typedef struct packed {
      logic        is_high_quality;
      logic        is_legacy;
      logic [15:0] page_total;
      logic [31:0] current_page_number;
      logic [7:0]  reading_direction;
      logic [2:0]  flag_bits;
      logic [63:0] metadata_start;
      logic [63:0] index_start;
      logic [63:0] pages_start;
      logic [63:0] thumbs_start;
      logic [63:0] chapters_start;
   } fields_type;

endpackage

// File: design/chv_front.sv
// Byte collector: shifts header bytes into a 56-byte line and hands a
// complete header record to the queue on the last byte. Depends on chv_pkg.
module chv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_value,
   input  logic                req_last_byte,
   input  logic                q_full,
   output logic                push,
   output chv_pkg::entry_type  push_entry
);
   import chv_pkg::*;

   logic [HDR_BITS-1:0] hdr_ff;
   logic [HDR_BITS-1:0] hdr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                accept;
   logic                room;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < CNT_W'(HDR_BYTES);

   // Newest byte enters at the top, so after 56 bytes byte k sits at bits 8k+7:8k.
   always_comb begin
      hdr_in   = hdr_ff;
      count_in = count_ff;
      if (accept) begin
         if (room) begin
            hdr_in   = {req_byte_value, hdr_ff[HDR_BITS-1:8]};
            count_in = count_ff + CNT_W'(1);
         end
         if (req_last_byte) begin
            count_in = '0;
         end
      end
   end

   assign push                 = accept && req_last_byte;
   assign push_entry.hdr       = hdr_in;
   assign push_entry.short_hdr = count_ff < CNT_W'(HDR_BYTES - 1);

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: design/chv_queue.sv
// Two-entry queue of header records between the byte collector and the checker.
// Depends on chv_pkg.
module chv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  chv_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                q_valid,
   output chv_pkg::entry_type  q_entry
);
   import chv_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full    = count_ff == 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: design/chv_back.sv
// Header checker: four-stage pipeline that decodes a header record, runs the
// range checks and drives the registered verdict. Depends on chv_pkg.
module chv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  chv_pkg::entry_type  q_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output chv_pkg::err_type    rsp_code,
   output chv_pkg::fields_type rsp_fields
);
   import chv_pkg::*;

   typedef struct packed {
      logic short_hdr;
      logic magic_ok;
      logic ver_ok;
      logic bad_pages;
      logic bad_idx;
      logic bad_meta;
      logic bad_chap;
      logic need_mod;
      logic bad_tail;
   } checks_type;

   logic advance;

   // Stage 1: decoded fields and the two end sums.
   logic       s1_valid_ff;
   logic       s1_short_ff, s1_magic_ok_ff, s1_ver_ok_ff;
   fields_type s1_fields_ff, s1_fields_in;
   logic [64:0] s1_meta_end_ff, s1_meta_end_in;
   logic [64:0] s1_idx_end_ff, s1_idx_end_in;
   logic       magic_ok, ver_ok, legacy, has_meta, has_chap;

   // Stage 2: comparison results and the chapter distance.
   logic       s2_valid_ff;
   fields_type s2_fields_ff;
   checks_type s2_checks_ff, s2_checks_in;
   logic [63:0] s2_diff_ff, s2_diff_in;
   logic [63:0] hdr_len;

   // Stage 3: chapter distance folded for the divide-by-three test.
   logic       s3_valid_ff;
   fields_type s3_fields_ff;
   checks_type s3_checks_ff;
   logic [17:0] s3_fold_ff, s3_fold_in;
   logic       s3_low_zero_ff;

   // Output register.
   logic       out_valid_ff;
   err_type    out_code_ff, out_code_in;
   fields_type out_fields_ff, out_fields_in;
   logic [9:0] red_a;
   logic [5:0] red_b;
   logic [3:0] red_c;
   logic       div96;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop     = advance && q_valid;

   always_comb begin
      magic_ok = (q_entry.hdr[31:0] == MAGIC_PLAIN) || (q_entry.hdr[31:0] == MAGIC_HQ);
      legacy   = q_entry.hdr[47:32] == VER_OLD;
      ver_ok   = (q_entry.hdr[47:32] == VER_NEW) || legacy;
      has_meta = |q_entry.hdr[79:72];
      has_chap = |q_entry.hdr[95:88];

      s1_meta_end_in = {1'b0, q_entry.hdr[191:128]} + META_LEN;
      s1_idx_end_in  = {1'b0, q_entry.hdr[255:192]} + {45'd0, q_entry.hdr[63:48], 4'd0};

      s1_fields_in.is_high_quality     = magic_ok && ver_ok && (q_entry.hdr[31:0] == MAGIC_HQ);
      s1_fields_in.is_legacy           = legacy;
      s1_fields_in.page_total          = q_entry.hdr[63:48];
      s1_fields_in.current_page_number = q_entry.hdr[127:96];
      s1_fields_in.reading_direction   = q_entry.hdr[71:64];
      s1_fields_in.flag_bits           = {has_chap, |q_entry.hdr[87:80], has_meta};
      s1_fields_in.metadata_start      = q_entry.hdr[191:128];
      s1_fields_in.index_start         = q_entry.hdr[255:192];
      s1_fields_in.pages_start         = q_entry.hdr[319:256];
      s1_fields_in.thumbs_start        = q_entry.hdr[383:320];
      if (!legacy) begin
         s1_fields_in.chapters_start = q_entry.hdr[447:384];
      end else if (!has_chap) begin
         s1_fields_in.chapters_start = '0;
      end else if (has_meta) begin
         s1_fields_in.chapters_start = s1_meta_end_in[63:0];
      end else begin
         s1_fields_in.chapters_start = HDR_LEN_OLD;
      end
      if (!(magic_ok && ver_ok)) begin
         s1_fields_in.thumbs_start   = '0;
         s1_fields_in.chapters_start = '0;
      end
   end

   always_comb begin
      hdr_len = s1_fields_ff.is_legacy ? HDR_LEN_OLD : HDR_LEN_NEW;

      s2_checks_in.short_hdr = s1_short_ff;
      s2_checks_in.magic_ok  = s1_magic_ok_ff;
      s2_checks_in.ver_ok    = s1_ver_ok_ff;
      s2_checks_in.bad_pages = s1_fields_ff.page_total == 16'd0;
      s2_checks_in.bad_idx   = (s1_fields_ff.index_start < hdr_len)
                            || (s1_fields_ff.pages_start <= s1_fields_ff.index_start)
                            || s1_idx_end_ff[64];
      if (s1_fields_ff.flag_bits[0]) begin
         s2_checks_in.bad_meta = (s1_fields_ff.metadata_start < hdr_len)
                              || s1_meta_end_ff[64]
                              || (s1_meta_end_ff[63:0] > s1_fields_ff.index_start);
      end else begin
         s2_checks_in.bad_meta = s1_fields_ff.metadata_start != '0;
      end
      if (s1_fields_ff.flag_bits[2]) begin
         s2_checks_in.bad_chap = (s1_fields_ff.chapters_start < hdr_len)
                              || (s1_fields_ff.chapters_start >= s1_fields_ff.index_start)
                              || (s1_fields_ff.flag_bits[0]
                                  && (s1_fields_ff.chapters_start < s1_meta_end_ff[63:0]));
      end else begin
         s2_checks_in.bad_chap = s1_fields_ff.chapters_start != '0;
      end
      s2_checks_in.need_mod = s1_fields_ff.flag_bits[2];
      s2_checks_in.bad_tail = s1_idx_end_ff[63:0] > s1_fields_ff.pages_start;
      s2_diff_in = s1_fields_ff.index_start - s1_fields_ff.chapters_start;
   end

   // 96 = 32 * 3: the low five bits must be zero and the value divisible by 3.
   // Since 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3, chunk sums keep the residue.
   assign s3_fold_in = {2'd0, s2_diff_ff[15:0]} + {2'd0, s2_diff_ff[31:16]}
                     + {2'd0, s2_diff_ff[47:32]} + {2'd0, s2_diff_ff[63:48]};

   always_comb begin
      red_a = {2'd0, s3_fold_ff[7:0]} + {2'd0, s3_fold_ff[15:8]} + {8'd0, s3_fold_ff[17:16]};
      red_b = {2'd0, red_a[3:0]} + {2'd0, red_a[7:4]} + {4'd0, red_a[9:8]};
      red_c = {2'd0, red_b[5:4]} + {2'd0, red_b[3:2]} + {2'd0, red_b[1:0]};
      div96 = s3_low_zero_ff && ((red_c == 4'd0) || (red_c == 4'd3) || (red_c == 4'd6));

      out_fields_in = s3_fields_ff;
      if (s3_checks_ff.short_hdr) begin
         out_code_in   = ERR_SHORT;
         out_fields_in = '0;
      end else if (!s3_checks_ff.magic_ok) begin
         out_code_in = ERR_MAGIC;
      end else if (!s3_checks_ff.ver_ok) begin
         out_code_in = ERR_VERSION;
      end else if (s3_checks_ff.bad_pages) begin
         out_code_in = ERR_PAGES;
      end else if (s3_checks_ff.bad_idx) begin
         out_code_in = ERR_INDEX;
      end else if (s3_checks_ff.bad_meta) begin
         out_code_in = ERR_META;
      end else if (s3_checks_ff.bad_chap || (s3_checks_ff.need_mod && !div96)) begin
         out_code_in = ERR_CHAPTERS;
      end else if (s3_checks_ff.bad_tail) begin
         out_code_in = ERR_INDEX;
      end else begin
         out_code_in = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_short_ff    <= q_entry.short_hdr;
         s1_magic_ok_ff <= magic_ok;
         s1_ver_ok_ff   <= ver_ok;
         s1_fields_ff   <= s1_fields_in;
         s1_meta_end_ff <= s1_meta_end_in;
         s1_idx_end_ff  <= s1_idx_end_in;
         s2_fields_ff   <= s1_fields_ff;
         s2_checks_ff   <= s2_checks_in;
         s2_diff_ff     <= s2_diff_in;
         s3_fields_ff   <= s2_fields_ff;
         s3_checks_ff   <= s2_checks_ff;
         s3_fold_ff     <= s3_fold_in;
         s3_low_zero_ff <= s2_diff_ff[4:0] == 5'd0;
         out_code_ff    <= out_code_in;
         out_fields_ff  <= out_fields_in;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_code   = out_code_ff;
   assign rsp_fields = out_fields_ff;

`ifndef NO_ASSERTIONS
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code == ERR_SHORT) |-> (rsp_fields == '0))
      else $error("short header verdict carries nonzero fields");

   a_hq_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fields.is_high_quality |->
         (rsp_code != ERR_MAGIC) && (rsp_code != ERR_VERSION) && (rsp_code != ERR_SHORT))
      else $error("high-quality flag set on a rejected header");

   a_ok_pages: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code == ERR_NONE) |->
         (rsp_fields.page_total != 16'd0)
         && (rsp_fields.pages_start > rsp_fields.index_start))
      else $error("accepted header with empty page range");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_valid_ff)
      else $error("queue pop did not load the first stage");
`endif

endmodule

// File: design/container_header_validator_core.sv
// Top level of the container header validator.
// Instantiates chv_front, chv_queue and chv_back; depends on chv_pkg.
//
// Usage:
//   Header bytes arrive on the req_ channel, one byte per request, in file
//   order. req_last_byte marks the final byte of a header buffer; bytes past
//   the 56th are dropped. Each marked request yields exactly one verdict on
//   the rsp_ channel: an error code naming the first failing check and the
//   decoded header fields. Unmarked requests yield nothing.
//   Throughput is one request per cycle while rsp_ready stays high, including
//   back-to-back one-byte headers. Once the request carrying a header's last
//   byte is accepted, the header passes through the two-entry header queue,
//   then three pipeline stages (decode and end sums, 64-bit compares,
//   chapter-spacing residue fold) ahead of the output register.
//   When a verdict waits and the receiver holds rsp_ready low, the checker
//   pipeline freezes as a whole; the byte collector keeps taking bytes until
//   two finished headers wait in the queue, then drops req_ready.
//   A synchronous reset empties the queue and pipeline and restarts byte
//   counting at the first header byte; the stored header bytes are not cleared.
module container_header_validator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_is_high_quality,
   output logic        rsp_is_legacy,
   output logic [15:0] rsp_page_total,
   output logic [31:0] rsp_current_page_number,
   output logic [7:0]  rsp_reading_direction,
   output logic [2:0]  rsp_flag_bits,
   output logic [63:0] rsp_metadata_start,
   output logic [63:0] rsp_index_start,
   output logic [63:0] rsp_pages_start,
   output logic [63:0] rsp_thumbs_start,
   output logic [63:0] rsp_chapters_start
);
   import chv_pkg::*;

   logic       q_full;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       q_valid;
   entry_type  q_entry;
   err_type    rsp_code;
   fields_type rsp_fields;

   chv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .q_full         (q_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   chv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   chv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_code   (rsp_code),
      .rsp_fields (rsp_fields)
   );

   // Break the verdict record out onto the individual result ports.
   assign rsp_error_code          = rsp_code;
   assign rsp_is_high_quality     = rsp_fields.is_high_quality;
   assign rsp_is_legacy           = rsp_fields.is_legacy;
   assign rsp_page_total          = rsp_fields.page_total;
   assign rsp_current_page_number = rsp_fields.current_page_number;
   assign rsp_reading_direction   = rsp_fields.reading_direction;
   assign rsp_flag_bits           = rsp_fields.flag_bits;
   assign rsp_metadata_start      = rsp_fields.metadata_start;
   assign rsp_index_start         = rsp_fields.index_start;
   assign rsp_pages_start         = rsp_fields.pages_start;
   assign rsp_thumbs_start        = rsp_fields.thumbs_start;
   assign rsp_chapters_start      = rsp_fields.chapters_start;

endmodule
